// ===== rtl/gif_lzw_decoder_assert.svh =====
// Assertion macros for the GIF LZW decoder.
// Plain concurrent property checks clocked on clock, disabled during reset.
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

`define GLZW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GLZW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   `GLZW_ASSERT(label, clk, rst, (pre) |=> (post), msg)

`endif

// ===== rtl/glzw_pkg.sv =====
// Shared constants for the GIF LZW decoder.
// Item kinds, result status codes, decoder run states and parameter defaults.
package glzw_pkg;

   localparam int TABLE_ENTRIES_DEF = 4096;
   localparam int MAX_CODE_BITS_DEF = 12;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_PULL = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [2:0] ST_PIXEL   = 3'd0;
   localparam logic [2:0] ST_NEED    = 3'd1;
   localparam logic [2:0] ST_DONE    = 3'd2;
   localparam logic [2:0] ST_ERROR   = 3'd3;
   localparam logic [2:0] ST_ACCEPT  = 3'd4;
   localparam logic [2:0] ST_REFUSE  = 3'd5;

   localparam logic [1:0] FIN_RUNNING = 2'd0;
   localparam logic [1:0] FIN_DONE    = 2'd1;
   localparam logic [1:0] FIN_FAILED  = 2'd2;

   localparam logic [7:0]  MCS_RESET    = 8'd8;
   localparam logic [24:0] PCOUNT_RESET = 25'd1;

   localparam logic CSR_MCS    = 1'b0;
   localparam logic CSR_PCOUNT = 1'b1;

endpackage

// ===== rtl/glzw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glzw_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/gif_lzw_decoder.sv =====
// GIF LZW decoder top level: control sequencer, bit packer and dictionary.
// Depends on glzw_pkg, glzw_ram and gif_lzw_decoder_assert.svh.
//
// Usage: req_kind selects a stream byte (sub-block length bytes included),
// a pull for the next pixel, or the end of the buffer. Every request yields
// exactly one response on rsp_*: a pixel, need byte, done, error, byte
// accepted or byte refused. csr_we writes min_code_size (index 0) or
// pixel_count (index 1) and restarts the decoder; write only while idle.
// A byte or end request answers from the execute state once the response
// register is free; the next request is taken after the return to idle.
// A pull served from the string stack reads the stack in the execute state
// and answers from the pop state, where the next request is taken in the
// same cycle the response is loaded. A pull that needs a new code decodes
// it (after any clear codes), walks the prefix chain through the registered
// prefix and suffix reads, and answers with the root pixel.
// Reset clears all control state; the dictionary and stack memories are
// not cleared, since every entry is written before it is read.
// A stalled receiver holds the response register; the decoder finishes the
// current request up to its result and then waits without further change.
module gif_lzw_decoder
   import glzw_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_pixel_index,
   output logic        rsp_last_pixel,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [24:0] csr_wdata
);

   `include "gif_lzw_decoder_assert.svh"

   localparam int TW  = $clog2(TABLE_ENTRIES);
   localparam int KW  = (MAX_CODE_BITS > TW) ? MAX_CODE_BITS : TW;
   localparam int NW  = $clog2(TABLE_ENTRIES + 1);
   localparam int SAW = $clog2(TABLE_ENTRIES + 2);
   localparam int CWW = $clog2(MAX_CODE_BITS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_ROOT   = 3'd4;
   localparam logic [2:0] S_POP    = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [1:0]     kind_ff, kind_in;
   logic [7:0]     byte_ff, byte_in;
   logic [7:0]     mcs_ff, mcs_in;
   logic [24:0]    pcount_ff, pcount_in;
   logic [SAW-1:0] depth_ff, depth_in;
   logic [23:0]    bitbuf_ff, bitbuf_in;
   logic [4:0]     bitcnt_ff, bitcnt_in;
   logic [7:0]     blkrem_ff, blkrem_in;
   logic           ended_ff, ended_in;
   logic [CWW-1:0] cw_ff, cw_in;
   logic [NW-1:0]  nfc_ff, nfc_in;
   logic [KW-1:0]  prev_ff, prev_in;
   logic           prev_valid_ff, prev_valid_in;
   logic [7:0]     prev_first_ff, prev_first_in;
   logic [24:0]    pix_ff, pix_in;
   logic [1:0]     fin_ff, fin_in;
   logic [KW-1:0]  code_ff, code_in;
   logic [7:0]     root_ff, root_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [7:0]     rsp_pixel_ff, rsp_pixel_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           tbl_we;
   logic [TW-1:0]  tbl_waddr, tbl_raddr;
   logic [KW-1:0]  prefix_rdata;
   logic [7:0]     suffix_rdata;
   logic           stk_we;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [7:0]     stk_wdata, stk_rdata;

   logic           go, mcs_ok, accept;
   logic [KW-1:0]  clear_code, eoi_code, cur_code, chain_code;
   logic [23:0]    code_mask;
   logic [NW-1:0]  nfc_inc;
   logic           emit, e_last;
   logic [2:0]     e_status;
   logic [7:0]     e_px;
   logic [24:0]    pix_inc;
   logic [7:0]     new_mcs;
   logic           new_ok;

   assign go        = !rsp_valid_ff || rsp_ready;
   assign mcs_ok    = (mcs_ff >= 8'd2) && (mcs_ff <= 8'd8);
   assign clear_code = KW'(1) << mcs_ff[3:0];
   assign eoi_code  = clear_code + KW'(1);
   assign code_mask = ~(24'hFFFFFF << cw_ff);
   assign cur_code  = KW'(bitbuf_ff & code_mask);
   assign nfc_inc   = nfc_ff + NW'(1);
   assign pix_inc   = pix_ff + 25'd1;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_POP) && go);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      mcs_in        = mcs_ff;
      pcount_in     = pcount_ff;
      depth_in      = depth_ff;
      bitbuf_in     = bitbuf_ff;
      bitcnt_in     = bitcnt_ff;
      blkrem_in     = blkrem_ff;
      ended_in      = ended_ff;
      cw_in         = cw_ff;
      nfc_in        = nfc_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      prev_first_in = prev_first_ff;
      pix_in        = pix_ff;
      fin_in        = fin_ff;
      code_in       = code_ff;
      root_in       = root_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      emit          = 1'b0;
      e_status      = ST_ACCEPT;
      e_px          = 8'd0;
      e_last        = 1'b0;
      tbl_we        = 1'b0;
      tbl_waddr     = nfc_ff[TW-1:0];
      tbl_raddr     = code_ff[TW-1:0];
      stk_we        = 1'b0;
      stk_waddr     = depth_ff;
      stk_wdata     = prev_first_ff;
      stk_raddr     = depth_ff;
      chain_code    = code_ff;
      new_mcs       = mcs_ff;
      new_ok        = 1'b0;

      unique case (state_ff)
         S_IDLE, S_EXEC, S_DECODE, S_WALK, S_ROOT, S_POP: begin
         end
         default: begin
         end
      endcase

      unique case (state_ff)
         S_IDLE: begin
         end
         S_EXEC: begin
            if (kind_ff == KIND_PULL) begin
               if (fin_ff == FIN_DONE) begin
                  if (go) begin emit = 1'b1; e_status = ST_DONE; end
               end else if (fin_ff != FIN_RUNNING) begin
                  if (go) begin emit = 1'b1; e_status = ST_ERROR; end
               end else if (!mcs_ok) begin
                  if (go) begin emit = 1'b1; e_status = ST_ERROR; fin_in = FIN_FAILED; end
               end else if (pix_ff >= pcount_ff) begin
                  if (go) begin emit = 1'b1; e_status = ST_DONE; fin_in = FIN_DONE; end
               end else if (depth_ff != '0) begin
                  depth_in  = depth_ff - SAW'(1);
                  stk_raddr = depth_ff - SAW'(1);
                  state_in  = S_POP;
               end else begin
                  state_in = S_DECODE;
               end
            end else if (go) begin
               emit     = 1'b1;
               e_status = ST_ACCEPT;
               case (kind_ff)
                  KIND_BYTE: begin
                     if (ended_ff || fin_ff != FIN_RUNNING) begin
                        e_status = ST_REFUSE;
                     end else if (blkrem_ff == 8'd0) begin
                        if (byte_ff == 8'd0) ended_in = 1'b1;
                        else blkrem_in = byte_ff;
                     end else if (bitcnt_ff > 5'd16) begin
                        e_status = ST_REFUSE;
                     end else begin
                        bitbuf_in = bitbuf_ff | (24'(byte_ff) << bitcnt_ff);
                        bitcnt_in = bitcnt_ff + 5'd8;
                        blkrem_in = blkrem_ff - 8'd1;
                     end
                  end
                  KIND_END: ended_in = 1'b1;
                  default:  e_status = ST_REFUSE;
               endcase
            end
         end
         S_DECODE: begin
            if (bitcnt_ff < {1'b0, cw_ff}) begin
               if (go) begin
                  emit = 1'b1;
                  if (ended_ff) begin e_status = ST_DONE; fin_in = FIN_DONE; end
                  else e_status = ST_NEED;
               end
            end else if (cur_code == clear_code) begin
               bitbuf_in     = bitbuf_ff >> cw_ff;
               bitcnt_in     = bitcnt_ff - 5'(cw_ff);
               cw_in         = CWW'(mcs_ff[3:0]) + CWW'(1);
               nfc_in        = NW'(eoi_code) + NW'(1);
               prev_valid_in = 1'b0;
            end else if (cur_code == eoi_code) begin
               if (go) begin
                  bitbuf_in = bitbuf_ff >> cw_ff;
                  bitcnt_in = bitcnt_ff - 5'(cw_ff);
                  emit = 1'b1; e_status = ST_DONE; fin_in = FIN_DONE;
               end
            end else if (16'(cur_code) >= 16'(nfc_ff)) begin
               if (!prev_valid_ff || 16'(cur_code) != 16'(nfc_ff)
                   || nfc_ff >= NW'(TABLE_ENTRIES)) begin
                  if (go) begin
                     bitbuf_in = bitbuf_ff >> cw_ff;
                     bitcnt_in = bitcnt_ff - 5'(cw_ff);
                     emit = 1'b1;
                     if (pix_ff != 25'd0) begin e_status = ST_DONE; fin_in = FIN_DONE; end
                     else begin e_status = ST_ERROR; fin_in = FIN_FAILED; end
                  end
               end else begin
                  bitbuf_in  = bitbuf_ff >> cw_ff;
                  bitcnt_in  = bitcnt_ff - 5'(cw_ff);
                  code_in    = cur_code;
                  stk_we     = 1'b1;
                  stk_wdata  = prev_first_ff;
                  depth_in   = depth_ff + SAW'(1);
                  chain_code = prev_ff;
               end
            end else begin
               bitbuf_in  = bitbuf_ff >> cw_ff;
               bitcnt_in  = bitcnt_ff - 5'(cw_ff);
               code_in    = cur_code;
               chain_code = cur_code;
            end
            if (bitcnt_ff >= {1'b0, cw_ff} && cur_code != clear_code
                && cur_code != eoi_code && state_in == S_DECODE && !emit
                && !(16'(cur_code) >= 16'(nfc_ff) && !stk_we)) begin
               tbl_raddr = chain_code[TW-1:0];
               root_in   = chain_code[7:0];
               state_in  = (chain_code > eoi_code) ? S_WALK : S_ROOT;
            end
         end
         S_WALK: begin
            stk_we     = 1'b1;
            stk_wdata  = suffix_rdata;
            depth_in   = depth_ff + SAW'(1);
            tbl_raddr  = prefix_rdata[TW-1:0];
            root_in    = prefix_rdata[7:0];
            if (prefix_rdata <= eoi_code) state_in = S_ROOT;
         end
         S_ROOT: begin
            if (go) begin
               if (prev_valid_ff && nfc_ff < NW'(TABLE_ENTRIES)) begin
                  tbl_we = 1'b1;
                  nfc_in = nfc_inc;
                  if (16'(nfc_inc) == (16'(1) << cw_ff) && cw_ff < CWW'(MAX_CODE_BITS))
                     cw_in = cw_ff + CWW'(1);
               end
               prev_in       = code_ff;
               prev_valid_in = 1'b1;
               prev_first_in = root_ff;
               pix_in        = pix_inc;
               emit          = 1'b1;
               e_status      = ST_PIXEL;
               e_px          = root_ff;
               e_last        = pix_inc >= pcount_ff;
               if (e_last) fin_in = FIN_DONE;
            end
         end
         S_POP: begin
            if (go) begin
               pix_in   = pix_inc;
               emit     = 1'b1;
               e_status = ST_PIXEL;
               e_px     = stk_rdata;
               e_last   = pix_inc >= pcount_ff;
               if (e_last) fin_in = FIN_DONE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = e_status;
         rsp_pixel_in  = e_px;
         rsp_last_in   = e_last;
         state_in      = S_IDLE;
      end

      if (accept) begin
         kind_in  = req_kind;
         byte_in  = req_data_byte;
         state_in = S_EXEC;
      end

      if (csr_we) begin
         if (csr_index == CSR_MCS) begin
            new_mcs = csr_wdata[7:0];
         end else begin
            pcount_in = csr_wdata;
         end
         new_ok        = (new_mcs >= 8'd2) && (new_mcs <= 8'd8);
         mcs_in        = new_mcs;
         depth_in      = '0;
         bitbuf_in     = '0;
         bitcnt_in     = '0;
         blkrem_in     = '0;
         ended_in      = 1'b0;
         prev_in       = '0;
         prev_valid_in = 1'b0;
         pix_in        = '0;
         fin_in        = FIN_RUNNING;
         cw_in         = new_ok ? CWW'(new_mcs[3:0]) + CWW'(1) : '0;
         nfc_in        = new_ok ? (NW'(1) << new_mcs[3:0]) + NW'(2) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mcs_ff        <= MCS_RESET;
         pcount_ff     <= PCOUNT_RESET;
         depth_ff      <= '0;
         bitbuf_ff     <= '0;
         bitcnt_ff     <= '0;
         blkrem_ff     <= '0;
         ended_ff      <= 1'b0;
         cw_ff         <= CWW'(MCS_RESET[3:0]) + CWW'(1);
         nfc_ff        <= (NW'(1) << MCS_RESET[3:0]) + NW'(2);
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         pix_ff        <= '0;
         fin_ff        <= FIN_RUNNING;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mcs_ff        <= mcs_in;
         pcount_ff     <= pcount_in;
         depth_ff      <= depth_in;
         bitbuf_ff     <= bitbuf_in;
         bitcnt_ff     <= bitcnt_in;
         blkrem_ff     <= blkrem_in;
         ended_ff      <= ended_in;
         cw_ff         <= cw_in;
         nfc_ff        <= nfc_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         pix_ff        <= pix_in;
         fin_ff        <= fin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      byte_ff       <= byte_in;
      prev_first_ff <= prev_first_in;
      code_ff       <= code_in;
      root_ff       <= root_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   glzw_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES), .ADDR_W(TW)) u_prefix (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (prev_ff),
      .raddr (tbl_raddr),
      .rdata (prefix_rdata)
   );

   glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES), .ADDR_W(TW)) u_suffix (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (root_ff),
      .raddr (tbl_raddr),
      .rdata (suffix_rdata)
   );

   glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES + 1), .ADDR_W(SAW)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_index = rsp_pixel_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   `GLZW_ASSERT(a_stack_bound, clock, reset,
      stk_we |-> (32'(depth_ff) < TABLE_ENTRIES + 1), "string stack overflow")
   `GLZW_ASSERT(a_pixel_count, clock, reset,
      (rsp_valid_ff && rsp_status_ff == ST_PIXEL) |-> (pix_ff != 25'd0),
      "pixel response without pixel count")
   `GLZW_ASSERT_NEXT(a_last_done, clock, reset,
      (emit && e_last && !csr_we), (fin_ff == FIN_DONE), "last pixel left decoder running")

endmodule

// ===== test/gif_lzw_decoder_tb.sv =====
// Self-checking testbench for gif_lzw_decoder: encodes random pixel runs into framed GIF
// LZW streams, feeds them with pulls under random idling, and checks every response.
// Depends on glzw_pkg and the gif_lzw_decoder RTL.
`timescale 1ns / 1ps

module gif_lzw_decoder_tb;
   import glzw_pkg::*;

   localparam logic [1:0] KIND_BAD = 2'd3;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] pixel;
      logic       last;
   } lzw_rsp_type;

   class lzw_scoreboard_type;
      logic [7:0]  code_size;
      logic [24:0] pix_total;
      logic [11:0] prefix_mem [4096];
      logic [7:0]  suffix_mem [4096];
      logic [7:0]  stack_mem [4097];
      int unsigned depth;
      logic [23:0] bit_buf;
      int unsigned bit_cnt;
      int unsigned blk_left;
      bit          ended;
      int unsigned width;
      int unsigned next_code;
      int unsigned prev_code;
      bit          prev_ok;
      int unsigned emitted;
      logic [1:0]  run_state;
      lzw_rsp_type pending [$];
      int          mismatches;

      function new();
         code_size = MCS_RESET;
         pix_total = PCOUNT_RESET;
         mismatches = 0;
         restart();
      endfunction

      function bit code_size_ok();
         return code_size >= 2 && code_size <= 8;
      endfunction

      function void restart();
         depth = 0;
         bit_buf = '0;
         bit_cnt = 0;
         blk_left = 0;
         ended = 0;
         prev_code = 0;
         prev_ok = 0;
         emitted = 0;
         run_state = FIN_RUNNING;
         if (code_size_ok()) begin
            width = code_size + 1;
            next_code = (1 << code_size) + 2;
         end else begin
            width = 0;
            next_code = 0;
         end
      endfunction

      function void write_reg(logic idx, logic [24:0] value);
         if (idx == CSR_MCS) code_size = value[7:0];
         else pix_total = value;
         restart();
      endfunction

      function void push_stack(logic [7:0] v);
         if (depth < 4097) begin
            stack_mem[depth] = v;
            depth++;
         end
      endfunction

      function logic [2:0] fill_stack();
         int unsigned clr, eoi, code, c, r;
         clr = 1 << code_size;
         eoi = clr + 1;
         while (depth == 0) begin
            if (bit_cnt < width) begin
               if (ended) begin
                  run_state = FIN_DONE;
                  return ST_DONE;
               end
               return ST_NEED;
            end
            code = bit_buf & ((1 << width) - 1);
            bit_buf = bit_buf >> width;
            bit_cnt -= width;
            if (code == clr) begin
               width = code_size + 1;
               next_code = eoi + 1;
               prev_ok = 0;
               continue;
            end
            if (code == eoi) begin
               run_state = FIN_DONE;
               return ST_DONE;
            end
            c = code;
            if (code >= next_code) begin
               if (!prev_ok || code != next_code || next_code >= 4096) begin
                  run_state = (emitted > 0) ? FIN_DONE : FIN_FAILED;
                  return (run_state == FIN_DONE) ? ST_DONE : ST_ERROR;
               end
               c = prev_code;
               r = c;
               while (r > eoi && r < 4096) r = prefix_mem[r];
               push_stack(r[7:0]);
            end
            while (c > eoi && c < 4096) begin
               push_stack(suffix_mem[c]);
               c = prefix_mem[c];
            end
            push_stack(c[7:0]);
            if (prev_ok && next_code < 4096) begin
               prefix_mem[next_code] = prev_code[11:0];
               suffix_mem[next_code] = c[7:0];
               next_code++;
               if (next_code == (1 << width) && width < 12) width++;
            end
            prev_code = code;
            prev_ok = 1;
         end
         return ST_PIXEL;
      endfunction

      function lzw_rsp_type decode(logic [1:0] kind, logic [7:0] data);
         lzw_rsp_type res;
         logic [2:0] st;
         res = '0;
         case (kind)
            KIND_BYTE: begin
               res.status = ST_ACCEPT;
               if (ended || run_state != FIN_RUNNING) res.status = ST_REFUSE;
               else if (blk_left == 0) begin
                  if (data == 0) ended = 1;
                  else blk_left = data;
               end else if (bit_cnt > 16) res.status = ST_REFUSE;
               else begin
                  bit_buf = bit_buf | (24'(data) << bit_cnt);
                  bit_cnt += 8;
                  blk_left--;
               end
            end
            KIND_END: begin
               ended = 1;
               res.status = ST_ACCEPT;
            end
            KIND_BAD: res.status = ST_REFUSE;
            default: begin
               if (run_state == FIN_DONE) res.status = ST_DONE;
               else if (run_state != FIN_RUNNING) res.status = ST_ERROR;
               else if (!code_size_ok()) begin
                  run_state = FIN_FAILED;
                  res.status = ST_ERROR;
               end else if (emitted >= pix_total) begin
                  run_state = FIN_DONE;
                  res.status = ST_DONE;
               end else begin
                  st = fill_stack();
                  res.status = st;
                  if (st == ST_PIXEL) begin
                     depth--;
                     res.pixel = stack_mem[depth];
                     emitted++;
                     res.last = (emitted >= pix_total);
                     if (res.last) run_state = FIN_DONE;
                  end
               end
            end
         endcase
         return res;
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] data);
         pending.push_back(decode(kind, data));
      endfunction

      function void check_response(lzw_rsp_type got);
         lzw_rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d pixel=%0d last=%0d",
                        got.status, got.pixel, got.last);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status=%0d pixel=%0d last=%0d, got %0d %0d %0d",
                        want.status, want.pixel, want.last, got.status, got.pixel, got.last);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_pixel_index;
   logic        rsp_last_pixel;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [24:0] csr_wdata = '0;

   lzw_scoreboard_type sb = new();
   logic [7:0] stream_q [$];
   logic [7:0] packed_q [$];
   longint unsigned pack_acc;
   int unsigned pack_n;
   int unsigned enc_w, enc_next;
   bit enc_prev;
   int idle_cycles = 0;

   gif_lzw_decoder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_pixel_index(rsp_pixel_index),
      .rsp_last_pixel(rsp_last_pixel),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 99) < 30) rsp_ready <= ($urandom_range(0, 3) == 0);
      else rsp_ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 50) == 0);
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_status, rsp_pixel_index, rsp_last_pixel});
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(logic [1:0] kind, logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_data_byte <= data;
      @(negedge clock);
      while (!req_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      sb.note_request(kind, data);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [24:0] value);
      drain();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic void put_code(int unsigned code, int unsigned mcs);
      pack_acc |= longint'(code) << pack_n;
      pack_n += enc_w;
      while (pack_n >= 8) begin
         packed_q.push_back(pack_acc[7:0]);
         pack_acc >>= 8;
         pack_n -= 8;
      end
      if (code == (1 << mcs)) begin
         enc_w = mcs + 1;
         enc_next = (1 << mcs) + 2;
         enc_prev = 0;
      end else begin
         if (enc_prev && enc_next < 4096) begin
            enc_next++;
            if (enc_next == (1 << enc_w) && enc_w < 12) enc_w++;
         end
         enc_prev = 1;
      end
   endfunction

   // Build a framed stream: LZW-encode npix random pixels, or random codes when noisy.
   function automatic void build_stream(int unsigned mcs, int unsigned npix, bit noisy,
                                        int clear_pct);
      int unsigned dict [int unsigned];
      int unsigned cur, c, key, dnext, clr, len, rem;
      clr = 1 << mcs;
      enc_w = mcs + 1;
      enc_next = clr + 2;
      enc_prev = 0;
      pack_acc = 0;
      pack_n = 0;
      packed_q.delete();
      stream_q.delete();
      if ($urandom_range(0, 9) < 7) put_code(clr, mcs);
      if (noisy) begin
         repeat (npix) put_code($urandom_range(0, (1 << enc_w) - 1), mcs);
      end else begin
         dnext = clr + 2;
         cur = $urandom_range(0, clr - 1);
         for (int i = 1; i < npix; i++) begin
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, clr - 1) : cur % clr;
            if ($urandom_range(0, 1)) c = $urandom_range(0, clr - 1);
            key = (cur << 8) | c;
            if (dict.exists(key)) cur = dict[key];
            else begin
               put_code(cur, mcs);
               if ($urandom_range(0, 999) < clear_pct) begin
                  put_code(clr, mcs);
                  dict.delete();
                  dnext = clr + 2;
               end else if (dnext < 4096) begin
                  dict[key] = dnext;
                  dnext++;
               end
               cur = c;
            end
         end
         put_code(cur, mcs);
      end
      if ($urandom_range(0, 9) < 8) put_code(clr + 1, mcs);
      if (pack_n > 0) packed_q.push_back(pack_acc[7:0]);
      rem = packed_q.size();
      while (rem > 0) begin
         len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 24);
         if (len > rem) len = rem;
         stream_q.push_back(len[7:0]);
         repeat (len) stream_q.push_back(packed_q.pop_front());
         rem -= len;
      end
      stream_q.push_back(8'd0);
   endfunction

   task automatic feed_stream(int noise_pct);
      int r, guard;
      guard = 0;
      while (sb.run_state == FIN_RUNNING && guard < 200000) begin
         guard++;
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            if ($urandom_range(0, 3) == 0) send(KIND_END, 8'($urandom));
            else send(KIND_BAD, 8'($urandom));
         end else if (stream_q.size() > 0 && (sb.blk_left == 0 || sb.bit_cnt <= 16)
                      && r < 65)
            send(KIND_BYTE, stream_q.pop_front());
         else if (stream_q.size() > 0 && r < 68)
            send(KIND_BYTE, stream_q[0]);
         else
            send(KIND_PULL, 8'($urandom));
      end
      send(KIND_PULL, 8'($urandom));
      send(KIND_BYTE, 8'($urandom));
   endtask

   task automatic run_phase(int unsigned mcs, int unsigned npix, int unsigned pcount,
                            bit noisy, int clear_pct, int noise_pct);
      write_csr(CSR_MCS, 25'(mcs));
      write_csr(CSR_PCOUNT, 25'(pcount));
      build_stream((mcs >= 2 && mcs <= 8) ? mcs : 8, npix, noisy, clear_pct);
      feed_stream(noise_pct);
   endtask

   initial begin
      int unsigned mcs, npix, pc;
      int sent_phases;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(KIND_PULL, 8'h00);
      send(KIND_BAD, 8'hFF);
      send(KIND_BYTE, 8'h00);
      send(KIND_BYTE, 8'hA5);
      send(KIND_PULL, 8'h00);
      send(KIND_END, 8'h00);
      send(KIND_PULL, 8'hFF);

      write_csr(CSR_MCS, 25'd0);
      send(KIND_PULL, 8'h00);
      send(KIND_PULL, 8'h00);
      send(KIND_BYTE, 8'h05);
      write_csr(CSR_MCS, 25'd255);
      send(KIND_PULL, 8'h00);

      write_csr(CSR_MCS, 25'd8);
      send(KIND_BYTE, 8'h05);
      send(KIND_BYTE, 8'hFF);
      send(KIND_BYTE, 8'hFF);
      send(KIND_BYTE, 8'hFF);
      send(KIND_BYTE, 8'hFF);
      send(KIND_PULL, 8'h00);
      send(KIND_PULL, 8'h00);

      run_phase(2, 12, 12, 0, 100, 0);
      run_phase(8, 10, 25'd16777216, 0, 0, 0);
      run_phase(2, 40, 40, 0, 0, 0);

      sent_phases = 0;
      while (sent_phases < 8) begin
         sent_phases++;
         mcs = $urandom_range(2, 8);
         if ($urandom_range(0, 9) == 0) mcs = $urandom_range(0, 1) ? 1 : 9;
         npix = $urandom_range(1, 30);
         case ($urandom_range(0, 3))
            0: pc = npix;
            1: pc = $urandom_range(1, npix);
            2: pc = npix + $urandom_range(1, 5);
            default: pc = ($urandom_range(0, 1)) ? 1 : 25'd16777216;
         endcase
         run_phase(mcs, npix, pc, $urandom_range(0, 4) == 0, 60, 4);
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
